// ----- hw/rtl/tds_pkg.sv -----
// tds_pkg: shared types and constants of the tabulated distribution sampler
// used by tds_divider and tabulated_distribution_sampler; no dependencies
package tds_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned FracBits   = 24;
  localparam int unsigned DvdW       = 41;  // probability shifted up by 16
  localparam int unsigned DvsW       = 25;

  // item kinds
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_STAIR  = 3'd1;
  localparam logic [2:0] OP_LINE   = 3'd2;
  localparam logic [2:0] OP_DISCR  = 3'd3;
  localparam logic [2:0] OP_RANK   = 3'd4;
  localparam logic [2:0] OP_RPROB  = 3'd5;
  localparam logic [2:0] OP_BIAS   = 3'd6;
  localparam logic [2:0] OP_NONE   = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PAST   = 2'd1;
  localparam logic [1:0] ST_ZBIN   = 2'd2;

  localparam logic [23:0] WeightOne = 24'h010000;
  localparam logic [23:0] WeightMax = 24'hFFFFFF;

  // one table row: all four tables share an address
  typedef struct packed {
    logic [24:0] cum;
    logic [24:0] bias;
    logic [31:0] val;
    logic [23:0] dens;
  } entry_t;

endpackage

// ----- hw/rtl/tds_divider.sv -----
// tds_divider: restoring unsigned divider, one quotient bit per cycle
// depends on tds_pkg for operand widths
module tds_divider
  import tds_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [DvdW-1:0] quot_o
);

  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DvsW:0]   shift;
  logic [DvsW:0]   diff;
  logic            ge;

  // one shift and trial subtract per cycle
  always_comb begin
    shift  = {rem_q, quo_q[DvdW-1]};
    diff   = shift - {1'b0, dvs_q};
    ge     = (shift >= {1'b0, dvs_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DvdW-2:0], ge};
      rem_d = ge ? diff[DvsW-1:0] : shift[DvsW-1:0];
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  // a result is flagged only at the end of a run
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without run");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && cnt_q != 6'(DvdW - 1) |=> busy_q)
    else $error("divider stopped early");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |=> rem_q < dvs_q) else $error("divider remainder too large");

endmodule

// ----- hw/rtl/tabulated_distribution_sampler.sv -----
// tabulated_distribution_sampler: inverse transform sampling from a table
// memory; depends on tds_pkg and tds_divider
//
// Usage: table rows are written by load transfers on the slave stream
// (tuser opcode 0); sample transfers (opcodes 1 to 6) search the cumulative
// or biased cumulative column for the first row at or above uniform_a and
// return one result on the master stream. Every input transfer, loads and
// the unused opcode included, gives exactly one result transfer.
// The entry count register is to be written on the cfg channel while idle;
// the block itself does not enforce this. Timing: a load passes from its input
// transfer to the output state, and from there to the output register once
// that is free. A sample takes one memory read and one compare per row
// searched, then two row reads, the density compare, the draw multiply and
// the output register; the biased staircase adds a run of the serial divider. One item is in work at a
// time; the next input is taken as soon as the previous result is in the
// output register, even while the receiver stalls it. A stalled result
// holds; a finished item waits until the output register is free.
// Reset clears control state and sets the entry count to 64; table rows
// are undefined until loaded and need no clearing pass.
module tabulated_distribution_sampler
  import tds_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [6:0]   cfg_data_i,     // entries_in_use
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index, cum_word, bias_cum_word, point_word, density_word,
  // uniform_a, uniform_b, uniform_c, uniform_d
  input  logic [207:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sample_value, rank, bin_probability, bias_weight, zero pad
  output logic [87:0]  m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // status
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_RDP  = 4'd3;
  localparam logic [3:0] S_RDC  = 4'd4;
  localparam logic [3:0] S_CAPC = 4'd5;
  localparam logic [3:0] S_MUL1 = 4'd6;
  localparam logic [3:0] S_SEL  = 4'd7;
  localparam logic [3:0] S_MUL2 = 4'd8;
  localparam logic [3:0] S_DRAW = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [6:0] cnt_cfg_q;

  // input fields
  logic [AddrW-1:0] in_idx;
  entry_t           in_row;
  logic [23:0]      in_ua, in_ub, in_uc, in_ud;
  logic             in_fire;

  assign in_idx       = s_axis_tdata[5:0];
  assign in_row.cum   = s_axis_tdata[30:6];
  assign in_row.bias  = s_axis_tdata[55:31];
  assign in_row.val   = s_axis_tdata[87:56];
  assign in_row.dens  = s_axis_tdata[111:88];
  assign in_ua        = s_axis_tdata[135:112];
  assign in_ub        = s_axis_tdata[159:136];
  assign in_uc        = s_axis_tdata[183:160];
  assign in_ud        = s_axis_tdata[207:184];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o  = 1'b1;

  // item registers
  logic [2:0]       op_q;
  logic [23:0]      ua_q, ub_q, uc_q, ud_q;
  logic [AddrW-1:0] idx_q, idx_d, rank_q, rank_d;
  logic             past_q, past_d;
  entry_t           prev_q, cur_q;
  logic [48:0]      lhs_q;
  logic [32:0]      diff_q;
  logic [23:0]      u_q, u_d;
  logic signed [57:0] prod_q;

  // result registers
  logic [31:0] r_sample_q, r_sample_d;
  logic [24:0] r_prob_q, r_prob_d;
  logic [23:0] r_weight_q, r_weight_d;
  logic [1:0]  r_status_q, r_status_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [87:0] out_data_q;
  logic [1:0]  out_user_q;

  // table memory
  entry_t           mem [TableDepth];
  entry_t           rd_q;
  logic             mem_we;
  logic [AddrW-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[in_idx] <= in_row;
    rd_q <= mem[rd_addr];
  end

  // effective entry count
  logic [6:0] n_eff, n_last;
  always_comb begin
    if (cnt_cfg_q < 7'd2) n_eff = 7'd2;
    else if (cnt_cfg_q > 7'(TableDepth)) n_eff = 7'(TableDepth);
    else n_eff = cnt_cfg_q;
    n_last = n_eff - 7'd1;
  end

  // divider
  logic            div_start, div_busy, div_done;
  logic [DvdW-1:0] div_quot;
  logic [25:0]     num, den;
  logic [24:0]     prob_b;

  assign num    = {1'b0, cur_q.cum} - {1'b0, prev_q.cum};
  assign den    = {1'b0, cur_q.bias} - {1'b0, prev_q.bias};
  assign prob_b = (!num[25] && num != 26'd0) ? num[24:0] : 25'd0;

  tds_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({prob_b, 16'd0}),
    .divisor_i  (den[24:0]),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // datapath helpers
  logic [24:0]  key;
  logic         hit;
  logic [23:0]  ymin;
  logic [24:0]  ysum;
  logic [48:0]  rhs;
  logic signed [57:0] prod_d;
  logic         need_prev;

  assign key       = (op_q == OP_BIAS) ? rd_q.bias : rd_q.cum;
  assign hit       = (key >= {1'b0, ua_q});
  assign ymin      = (prev_q.dens < cur_q.dens) ? prev_q.dens : cur_q.dens;
  assign ysum      = {1'b0, prev_q.dens} + {1'b0, cur_q.dens};
  assign rhs       = {ymin, 1'b0, 24'd0};
  assign prod_d    = $signed(diff_q) * $signed({1'b0, u_q});
  assign need_prev = (op_q == OP_STAIR) || (op_q == OP_LINE) || (op_q == OP_BIAS);

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rank_d     = rank_q;
    past_d     = past_q;
    u_d        = u_q;
    r_sample_d = r_sample_q;
    r_prob_d   = r_prob_q;
    r_weight_d = r_weight_q;
    r_status_d = r_status_q;
    mem_we     = 1'b0;
    rd_addr    = idx_q;
    div_start  = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          r_sample_d = '0;
          r_prob_d   = '0;
          r_status_d = ST_OK;
          idx_d      = '0;
          rank_d     = '0;
          past_d     = 1'b0;
          if (s_axis_tuser == OP_LOAD || s_axis_tuser == OP_NONE) begin
            mem_we     = (s_axis_tuser == OP_LOAD);
            r_weight_d = '0;
            state_d    = S_OUT;
          end else begin
            r_weight_d = WeightOne;
            state_d    = S_RD;
          end
        end
      end
      S_RD: begin
        rd_addr = idx_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (hit || idx_q == n_last[AddrW-1:0]) begin
          past_d  = !hit;
          rank_d  = (need_prev && idx_q == '0) ? AddrW'(1) : idx_q;
          state_d = S_RDP;
        end else begin
          idx_d   = idx_q + AddrW'(1);
          state_d = S_RD;
        end
      end
      S_RDP: begin
        rd_addr = (rank_q == '0) ? '0 : rank_q - AddrW'(1);
        state_d = S_RDC;
      end
      S_RDC: begin
        rd_addr = rank_q;
        state_d = S_CAPC;
      end
      S_CAPC: state_d = S_MUL1;
      S_MUL1: state_d = S_SEL;
      S_SEL: begin
        if (op_q != OP_LINE || lhs_q <= rhs) u_d = (op_q == OP_LINE) ? uc_q : ub_q;
        else if (prev_q.dens <= cur_q.dens) u_d = (uc_q > ud_q) ? uc_q : ud_q;
        else u_d = (uc_q < ud_q) ? uc_q : ud_q;
        state_d = S_MUL2;
      end
      S_MUL2: state_d = S_DRAW;
      S_DRAW: begin
        r_status_d = past_q ? ST_PAST : ST_OK;
        state_d    = S_OUT;
        case (op_q)
          OP_STAIR, OP_LINE: r_sample_d = prev_q.val + prod_q[55:24];
          OP_DISCR: r_sample_d = cur_q.val;
          OP_RPROB: begin
            if (rank_q == '0) r_prob_d = cur_q.cum;
            else if (cur_q.cum >= prev_q.cum) r_prob_d = cur_q.cum - prev_q.cum;
            else r_prob_d = '0;
          end
          OP_BIAS: begin
            r_sample_d = prev_q.val + prod_q[55:24];
            r_prob_d   = prob_b;
            if (den[25] || den == 26'd0) begin
              r_weight_d = WeightMax;
              r_status_d = ST_ZBIN;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          r_weight_d = (div_quot > DvdW'(WeightMax)) ? WeightMax : div_quot[23:0];
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_cfg_q   <= 7'(TableDepth);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) cnt_cfg_q <= cfg_data_i;
    end
  end

  function automatic logic [48:0] in_ub_mul(input logic [23:0] a, input logic [24:0] b);
    in_ub_mul = a * b;
  endfunction

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= s_axis_tuser;
      ua_q <= in_ua;
      ub_q <= in_ub;
      uc_q <= in_uc;
      ud_q <= in_ud;
    end
    idx_q      <= idx_d;
    rank_q     <= rank_d;
    past_q     <= past_d;
    u_q        <= u_d;
    r_sample_q <= r_sample_d;
    r_prob_q   <= r_prob_d;
    r_weight_q <= r_weight_d;
    r_status_q <= r_status_d;
    if (state_q == S_RDC) prev_q <= rd_q;
    if (state_q == S_CAPC) cur_q <= rd_q;
    if (state_q == S_MUL1) begin
      lhs_q  <= in_ub_mul(ub_q, ysum);
      diff_q <= {cur_q.val[31], cur_q.val} - {prev_q.val[31], prev_q.val};
    end
    if (state_q == S_MUL2) prod_q <= prod_d;
    if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {1'b0, r_weight_q, r_prob_q, rank_q, r_sample_q};
      out_user_q <= r_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready) else $error("input taken twice in a row");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3) else $error("bad status code");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> {1'b0, idx_q} <= n_last) else $error("search past entry count");

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for tabulated_distribution_sampler
// depends on tds_pkg and the sampler rtl; table loads, directed and random draws
module tb_top
  import tds_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  idx;
    logic [24:0] cum;
    logic [24:0] bcum;
    logic [31:0] pt;
    logic [23:0] dens;
    logic [23:0] ua;
    logic [23:0] ub;
    logic [23:0] uc;
    logic [23:0] ud;
  } item_t;

  typedef struct packed {
    logic [31:0] sval;
    logic [5:0]  rnk;
    logic [24:0] prob;
    logic [23:0] wgt;
    logic [1:0]  st;
  } draw_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [6:0]   cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  tabulated_distribution_sampler dut (.*);

  // predictor state
  logic [24:0] cum_q [TableDepth];
  logic [24:0] bias_q [TableDepth];
  logic [31:0] val_q [TableDepth];
  logic [23:0] dens_q [TableDepth];
  logic [6:0]  n_cfg;

  draw_t expected_draws[$];
  int    mismatches = 0;
  int    cycles = 0;
  int    send_idle = 33;
  int    recv_idle = 65;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // uniform draw between two points, floor of width times fraction
  function automatic logic [31:0] draw_span(logic [31:0] lo, logic [31:0] hi,
                                            logic [23:0] u);
    longint a;
    longint p;
    a = longint'($signed(lo));
    p = (longint'($signed(hi)) - a) * longint'({40'd0, u});
    return 32'(a + (p >>> 24));
  endfunction

  // expected result of one item, updates the tables on loads
  function automatic draw_t predict_draw(logic [2:0] op, item_t it);
    draw_t r;
    int n;
    int i;
    bit past;
    longint num;
    longint den;
    longint w;
    logic [63:0] y0;
    logic [63:0] y1;
    logic [63:0] ymin;
    logic [23:0] u;
    r = '0;
    past = 1'b0;
    if (op == OP_LOAD) begin
      cum_q[it.idx] = it.cum;
      bias_q[it.idx] = it.bcum;
      val_q[it.idx] = it.pt;
      dens_q[it.idx] = it.dens;
      return r;
    end
    if (op == OP_NONE) return r;
    r.wgt = WeightOne;
    n = n_cfg;
    if (n < 2) n = 2;
    if (n > TableDepth) n = TableDepth;
    i = -1;
    for (int k = 0; k < n; k++) begin
      if (i < 0 && ((op == OP_BIAS) ? bias_q[k] : cum_q[k]) >= {1'b0, it.ua}) i = k;
    end
    if (i < 0) begin
      i = n - 1;
      past = 1'b1;
    end
    if ((op == OP_STAIR || op == OP_LINE || op == OP_BIAS) && i == 0) i = 1;
    if (past) r.st = ST_PAST;
    case (op)
      OP_STAIR: r.sval = draw_span(val_q[i-1], val_q[i], it.ub);
      OP_LINE: begin
        y0 = dens_q[i-1];
        y1 = dens_q[i];
        ymin = (y0 < y1) ? y0 : y1;
        if (64'(it.ub) * (y0 + y1) <= ((2 * ymin) << 24)) u = it.uc;
        else if (y0 <= y1) u = (it.uc > it.ud) ? it.uc : it.ud;
        else u = (it.uc < it.ud) ? it.uc : it.ud;
        r.sval = draw_span(val_q[i-1], val_q[i], u);
      end
      OP_DISCR: r.sval = val_q[i];
      OP_RPROB: begin
        if (i == 0) r.prob = cum_q[0];
        else if (cum_q[i] >= cum_q[i-1]) r.prob = cum_q[i] - cum_q[i-1];
      end
      OP_BIAS: begin
        num = longint'(cum_q[i]) - longint'(cum_q[i-1]);
        den = longint'(bias_q[i]) - longint'(bias_q[i-1]);
        r.sval = draw_span(val_q[i-1], val_q[i], it.ub);
        r.prob = (num > 0) ? 25'(num) : '0;
        if (den <= 0) begin
          r.wgt = WeightMax;
          r.st = ST_ZBIN;
        end else begin
          w = (longint'(r.prob) << 16) / den;
          r.wgt = (w > 64'hFFFFFF) ? WeightMax : 24'(w);
        end
      end
      default: ;
    endcase
    r.rnk = 6'(i);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    draw_t got;
    draw_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tdata[62:38],
             m_axis_tdata[86:63], m_axis_tuser};
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_draws.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value %h/%h rank %0d/%0d prob %h/%h wgt %h/%h st %0d/%0d",
                     want.sval, got.sval, want.rnk, got.rnk, want.prob, got.prob,
                     want.wgt, got.wgt, want.st, got.st);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // valid stays up after a transfer so items can follow back to back;
  // it drops while the sender idles or a caller pauses the stream
  task automatic send_item(logic [2:0] op, item_t it);
    draw_t r;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {it.ud, it.uc, it.ub, it.ua, it.dens, it.pt, it.bcum, it.cum, it.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_draw(op, it);
    expected_draws.push_back(r);
  endtask

  task automatic load_row(int idx, logic [24:0] c, logic [24:0] b, logic [31:0] p,
                          logic [23:0] d);
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.idx = 6'(idx);
    it.cum = c;
    it.bcum = b;
    it.pt = p;
    it.dens = d;
    send_item(OP_LOAD, it);
  endtask

  task automatic set_entries(logic [6:0] n);
    s_axis_tvalid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_cfg = n;
  endtask

  // a table over all 64 rows: an even staircase (shape 0) or a random one with some flat or decreasing steps
  task automatic fill_table(int shape);
    logic [24:0] c;
    logic [24:0] b;
    int  p;
    c = 0;
    b = 0;
    p = $urandom;
    for (int k = 0; k < TableDepth; k++) begin
      if (shape == 0) begin
        c = (k == TableDepth - 1) ? 25'h1000000 : 25'((k + 1) * 262144);
        b = c;
      end else begin
        if ($urandom_range(9) == 0) c = c - 25'($urandom_range(1000));
        else c = c + 25'($urandom_range(500000));
        if ($urandom_range(7) == 0) b = b;
        else b = b + 25'($urandom_range(500000));
        if (k == TableDepth - 1 && $urandom_range(1)) begin
          c = 25'h1000000;
          b = 25'h1000000;
        end
      end
      p = p + (($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(200000)) - 50000);
      load_row(k, c, b, 32'(p), ($urandom_range(5) == 0) ? 24'd0 : 24'($urandom));
    end
  endtask

  task automatic random_draw();
    item_t it;
    logic [2:0] op;
    it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    op = 3'($urandom_range(1, 7));
    if ($urandom_range(7) == 0) it.ua = 24'hFFFFFF;
    if ($urandom_range(9) == 0) it.ua = 24'd0;
    send_item(op, it);
  endtask

  // directed rows: op, fields; uniforms mostly at the extremes
  typedef struct {
    logic [2:0]  op;
    logic [23:0] ua;
    logic [23:0] ub;
    logic [23:0] uc;
    logic [23:0] ud;
  } row_t;

  row_t plan[] = '{
    '{OP_DISCR, 24'd0, 24'd0, 24'd0, 24'd0},
    '{OP_RANK, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
    '{OP_STAIR, 24'd0, 24'hFFFFFF, 24'd0, 24'd0},
    '{OP_STAIR, 24'h800000, 24'd0, 24'd0, 24'd0},
    '{OP_LINE, 24'd0, 24'hFFFFFF, 24'h123456, 24'hFEDCBA},
    '{OP_LINE, 24'h400000, 24'd0, 24'hFFFFFF, 24'd0},
    '{OP_LINE, 24'hC00000, 24'h7FFFFF, 24'd5, 24'hFFFFF0},
    '{OP_RPROB, 24'd0, 24'd0, 24'd0, 24'd0},
    '{OP_RPROB, 24'hFFFFFF, 24'd0, 24'd0, 24'd0},
    '{OP_BIAS, 24'd0, 24'h555555, 24'd0, 24'd0},
    '{OP_BIAS, 24'hFFFFFF, 24'hAAAAAA, 24'd0, 24'd0},
    '{OP_BIAS, 24'h300000, 24'hFFFFFF, 24'd0, 24'd0},
    '{OP_NONE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}
  };

  initial begin
    item_t it;
    n_cfg = 7'd64;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: even staircase, then a table with signed extremes
    fill_table(0);
    load_row(0, 25'd0, 25'd0, 32'h80000000, 24'hFFFFFF);
    load_row(1, 25'h1000000, 25'h1000000, 32'h7FFFFFFF, 24'd0);
    load_row(2, 25'h0FFFFFF, 25'h1000000, 32'hFFFFFFFF, 24'd0);
    foreach (plan[k]) begin
      it = '0;
      it.ua = plan[k].ua;
      it.ub = plan[k].ub;
      it.uc = plan[k].uc;
      it.ud = plan[k].ud;
      send_item(plan[k].op, it);
    end
    // rank on a fresh entry count of two with a search past the end
    set_entries(7'd2);
    load_row(1, 25'd100, 25'd100, 32'd5, 24'd1);
    it = '0;
    it.ua = 24'hFFFFFF;
    send_item(OP_RANK, it);
    expected_draws[$] = '{32'd0, 6'd1, 25'd0, WeightOne, ST_PAST};

    // random phases over several entry counts and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle = 65;
        recv_idle = 33;
      end
      if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        0: set_entries(7'd64);
        1: set_entries(7'd0);
        2: set_entries(7'd127);
        3: set_entries(7'($urandom_range(3, 63)));
        4: set_entries(7'd1);
        default: set_entries(7'($urandom_range(2, 64)));
      endcase
      fill_table(1);
      for (int k = 0; k < 100; k++) random_draw();
    end

    s_axis_tvalid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
